// ===== rtl/core/ppu_pkg.sv =====
// ppu_pkg: shared constants and helpers of the polygon perimeter unit.
// No dependencies; imported by ppu_isqrt and polygon_perimeter_unit.
package ppu_pkg;

  localparam int unsigned CoordW       = 16;
  localparam int unsigned PerimW       = 35;
  localparam int unsigned CountW       = 11;
  localparam int unsigned RadW         = 34;
  localparam int unsigned CountLimit   = 2047;
  localparam int unsigned FracBitsDef  = 8;
  localparam int unsigned MaxVertsDef  = 1024;

  // |b - a| of two signed coordinates; fits CoordW bits unsigned
  function automatic logic [CoordW-1:0] abs_diff(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b);
    logic [CoordW:0] d;
    d = {b[CoordW-1], b} - {a[CoordW-1], a};
    if (d[CoordW]) begin
      d = ~d + 1'b1;
    end
    return d[CoordW-1:0];
  endfunction

endpackage

// ===== rtl/core/ppu_isqrt.sv =====
// ppu_isqrt: bit-serial restoring square root, floor(sqrt(rad * 4^FRAC_BITS)).
// One root bit per cycle, radicand fed two bits a cycle from a shift register.
// Depends on ppu_pkg.
module ppu_isqrt import ppu_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [RadW-1:0]             radicand_i,
  output logic                        done_o,
  output logic [FRAC_BITS+RadW/2-1:0] root_o
);

  localparam int unsigned Steps = FRAC_BITS + RadW / 2;
  localparam int unsigned RootW = Steps;
  localparam int unsigned RemW  = RootW + 2;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [RemW-1:0]  rem_sh;
  logic [RemW-1:0]  trial;
  logic             fits;

  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rad_q  <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= CntW'(Steps);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rad_q  <= {rad_q[RadW-3:0], 2'b00};
        rem_q  <= fits ? (rem_sh - trial) : rem_sh;
        root_q <= {root_q[RootW-2:0], fits};
        cnt_q  <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/polygon_perimeter_unit.sv =====
// polygon_perimeter_unit: Euclidean perimeter of a streamed polygon.
// Depends on ppu_pkg and ppu_isqrt.
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_stall_o  vertex_x_i, vertex_y_i, last_vertex_i
//   out      output     out_valid_o/out_stall_i perimeter_len_o, vertex_count_o, overflow_o
//
// The first vertex of a polygon is only stored. Every other vertex passes a
// transfer, the multiply states ST_SQ1 and ST_SQ2, FRAC_BITS + 17 root steps
// of the shared bit-serial square root and a handoff into the sum. After the
// last vertex's edge the closing edge takes the same path, then ST_OUT posts
// the result; a single-vertex polygon runs only the closing edge. Reset clears
// all state; a stalled result holds in the output register while the next
// polygon starts, and the next result waits in ST_OUT until it drains.
module polygon_perimeter_unit import ppu_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVertsDef,
  parameter int unsigned FRAC_BITS    = FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CoordW-1:0] vertex_x_i,
  input  logic [CoordW-1:0] vertex_y_i,
  input  logic              last_vertex_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PerimW-1:0] perimeter_len_o,
  output logic [CountW-1:0] vertex_count_o,
  output logic              overflow_o
);

  localparam int unsigned RootW = FRAC_BITS + RadW / 2;
  localparam int unsigned SumW  = PerimW + 1;
  localparam logic [CountW-1:0] CntCap =
    CountW'((MAX_VERTICES < CountLimit) ? MAX_VERTICES : CountLimit);
  localparam logic [PerimW-1:0] SumMax = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ1,
    ST_SQ2,
    ST_ROOT,
    ST_CLOSE,
    ST_OUT
  } state_e;

  state_e            state_q;
  logic [CoordW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic [CoordW-1:0] ux_q, uy_q;
  logic [RadW-1:0]   sq_q;
  logic [PerimW-1:0] sum_q;
  logic [CountW-1:0] count_q;
  logic              sat_q, last_q, closing_q;
  logic              out_valid_q;
  logic [PerimW-1:0] out_len_q;
  logic [CountW-1:0] out_count_q;
  logic              out_ovf_q;

  logic              in_xfer;
  logic              sqrt_start;
  logic [RadW-1:0]   radicand;
  logic              sqrt_done;
  logic [RootW-1:0]  root;
  logic [SumW-1:0]   sum_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && (state_q == ST_IDLE);
  assign sqrt_start = (state_q == ST_SQ2);
  assign radicand   = sq_q + RadW'(32'(uy_q) * 32'(uy_q));
  assign sum_ext    = {1'b0, sum_q} + SumW'(root);

  ppu_isqrt #(
    .FRAC_BITS(FRAC_BITS)
  ) u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .radicand_i(radicand),
    .done_o    (sqrt_done),
    .root_o    (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      ux_q        <= '0;
      uy_q        <= '0;
      sq_q        <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      sat_q       <= 1'b0;
      last_q      <= 1'b0;
      closing_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_len_q   <= '0;
      out_count_q <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            last_q   <= last_vertex_i;
            prev_x_q <= vertex_x_i;
            prev_y_q <= vertex_y_i;
            if (count_q == '0) begin
              first_x_q <= vertex_x_i;
              first_y_q <= vertex_y_i;
              count_q   <= CountW'(1);
              state_q   <= last_vertex_i ? ST_CLOSE : ST_IDLE;
            end else begin
              ux_q <= abs_diff(prev_x_q, vertex_x_i);
              uy_q <= abs_diff(prev_y_q, vertex_y_i);
              if (count_q >= CntCap) begin
                count_q <= CntCap;
                sat_q   <= 1'b1;
              end else begin
                count_q <= count_q + CountW'(1);
              end
              state_q <= ST_SQ1;
            end
          end
        end
        ST_SQ1: begin
          sq_q    <= RadW'(32'(ux_q) * 32'(ux_q));
          state_q <= ST_SQ2;
        end
        ST_SQ2: begin
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            if (sum_ext > SumW'(SumMax)) begin
              sum_q <= SumMax;
              sat_q <= 1'b1;
            end else begin
              sum_q <= sum_ext[PerimW-1:0];
            end
            if (last_q && !closing_q) begin
              state_q <= ST_CLOSE;
            end else if (last_q) begin
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_CLOSE: begin
          ux_q      <= abs_diff(prev_x_q, first_x_q);
          uy_q      <= abs_diff(prev_y_q, first_y_q);
          closing_q <= 1'b1;
          state_q   <= ST_SQ1;
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_len_q   <= sum_q;
            out_count_q <= count_q;
            out_ovf_q   <= sat_q;
            first_x_q   <= '0;
            first_y_q   <= '0;
            prev_x_q    <= '0;
            prev_y_q    <= '0;
            sum_q       <= '0;
            count_q     <= '0;
            sat_q       <= 1'b0;
            last_q      <= 1'b0;
            closing_q   <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign perimeter_len_o = out_len_q;
  assign vertex_count_o  = out_count_q;
  assign overflow_o      = out_ovf_q;

endmodule
